FILE: rtl/ssc_pkg.sv
package ssc_pkg;

  localparam int NUM_PHASES = 3;
  localparam int PHASE_A    = 0;
  localparam int PHASE_B    = 1;
  localparam int PHASE_C    = 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_DUTY      = 2'd0;
  localparam logic [1:0] REG_PROP_GAIN     = 2'd1;
  localparam logic [1:0] REG_INTEGRAL_GAIN = 2'd2;

  localparam logic [15:0] MAX_DUTY_RESET      = 16'd0;
  localparam logic [15:0] PROP_GAIN_RESET     = 16'd15;
  localparam logic [15:0] INTEGRAL_GAIN_RESET = 16'd7000;

  // What a phase does in a given Hall sector.
  localparam logic [2:0] ROLE_NONE     = 3'd0;
  localparam logic [2:0] ROLE_HALF     = 3'd1;
  localparam logic [2:0] ROLE_FULL     = 3'd2;
  localparam logic [2:0] ROLE_NEG_HALF = 3'd3;
  localparam logic [2:0] ROLE_IDLE     = 3'd4;

  typedef struct packed {
    logic               enable;
    logic [2:0]         sector;
    logic signed [15:0] current_request;
    logic signed [15:0] current_a;
    logic signed [15:0] current_b;
    logic signed [15:0] current_c;
  } ssc_sample_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic        gates_on;
  } ssc_result_t;

  typedef struct packed {
    logic load;
    logic step;
    logic preset;
  } lane_ctrl_t;

  typedef struct packed {
    logic       advance;
    logic       valid;
    logic       enable;
    logic [2:0] sector;
  } stage_ctrl_t;

  // Sectors 0, 2 and 4 drive two phases and leave one idle; sectors 1, 3 and 5
  // drive one phase at full request against the other two; 6 and 7 hold.
  function automatic logic [2:0] lane_role(logic [2:0] sector, int lane);
    logic [2:0] role;
    unique case (sector)
      3'd0: role = (lane == PHASE_C) ? ROLE_IDLE : ROLE_HALF;
      3'd1: role = (lane == PHASE_B) ? ROLE_FULL : ROLE_NEG_HALF;
      3'd2: role = (lane == PHASE_A) ? ROLE_IDLE : ROLE_HALF;
      3'd3: role = (lane == PHASE_C) ? ROLE_FULL : ROLE_NEG_HALF;
      3'd4: role = (lane == PHASE_B) ? ROLE_IDLE : ROLE_HALF;
      3'd5: role = (lane == PHASE_A) ? ROLE_FULL : ROLE_NEG_HALF;
      default: role = ROLE_NONE;
    endcase
    return role;
  endfunction

endpackage

FILE: rtl/ssc_lane.sv
module ssc_lane
  import ssc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  lane_ctrl_t         ctrl,
  input  logic signed [16:0] target,
  input  logic signed [15:0] meas,
  input  logic [15:0]        max_duty,
  input  logic [15:0]        prop_gain,
  input  logic [15:0]        integral_gain,
  input  logic signed [31:0] preset_integ,
  input  logic [15:0]        preset_duty,
  output logic signed [31:0] step_integ,
  output logic [15:0]        step_duty
);

  localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
  localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

  // Front stage: error and both gain products depend only on the sample and the gains.
  logic signed [16:0] err;
  logic signed [33:0] prod_i_d;
  logic signed [33:0] prod_p_d;
  logic signed [34:0] pm_d;

  assign err      = target - {meas[15], meas};
  assign prod_i_d = err * $signed({1'b0, integral_gain});
  assign prod_p_d = err * $signed({1'b0, prop_gain});
  assign pm_d     = {prod_p_d[33], prod_p_d} - {{19{meas[15]}}, meas};

  logic               err_pos;
  logic               err_neg;
  logic signed [33:0] prod_i;
  logic signed [34:0] pm;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      err_pos <= !err[16] && (err != 17'sd0);
      err_neg <= err[16];
      prod_i  <= prod_i_d;
      pm      <= pm_d;
    end
  end

  // Phase state.
  logic signed [31:0] integ;
  logic [15:0]        duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      duty  <= '0;
    end else if (ctrl.step) begin
      integ <= step_integ;
      duty  <= step_duty;
    end else if (ctrl.preset) begin
      integ <= preset_integ;
      duty  <= preset_duty;
    end
  end

  // Back stage: anti-windup hold, saturating integrator, duty clamp.
  logic               hold;
  logic signed [34:0] isum;
  logic signed [35:0] dsum;
  logic signed [28:0] dq;

  assign hold = (err_pos && (duty == max_duty)) || (err_neg && (duty == 16'd0));
  assign isum = {{3{integ[31]}}, integ} + {prod_i[33], prod_i};

  always_comb begin
    if (hold) begin
      step_integ = integ;
    end else if (isum > SAT_HI) begin
      step_integ = SAT_HI[31:0];
    end else if (isum < SAT_LO) begin
      step_integ = SAT_LO[31:0];
    end else begin
      step_integ = isum[31:0];
    end
  end

  assign dsum = {pm[34], pm} + {{14{step_integ[31]}}, step_integ[31:10]};
  assign dq   = dsum[35:7];

  always_comb begin
    if (dq[28]) begin
      step_duty = 16'd0;
    end else if (dq[27:0] > {12'd0, max_duty}) begin
      step_duty = max_duty;
    end else begin
      step_duty = dq[15:0];
    end
  end

endmodule

FILE: rtl/ssc_merge.sv
module ssc_merge
  import ssc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  stage_ctrl_t        ctrl,
  input  logic signed [31:0] step_integ [NUM_PHASES],
  input  logic [15:0]        step_duty [NUM_PHASES],
  output logic signed [31:0] preset_integ,
  output logic [15:0]        preset_duty,
  output ssc_result_t        result,
  output logic               result_valid
);

  // The idle phase is preset from the two phases driven in the same sector.
  logic signed [31:0] i1;
  logic signed [31:0] i2;
  logic [15:0]        d1;
  logic [15:0]        d2;

  always_comb begin
    case (ctrl.sector)
      3'd2: begin
        i1 = step_integ[PHASE_B];
        i2 = step_integ[PHASE_C];
        d1 = step_duty[PHASE_B];
        d2 = step_duty[PHASE_C];
      end
      3'd4: begin
        i1 = step_integ[PHASE_A];
        i2 = step_integ[PHASE_C];
        d1 = step_duty[PHASE_A];
        d2 = step_duty[PHASE_C];
      end
      default: begin
        i1 = step_integ[PHASE_A];
        i2 = step_integ[PHASE_B];
        d1 = step_duty[PHASE_A];
        d2 = step_duty[PHASE_B];
      end
    endcase
  end

  logic [16:0]        dsum;
  logic signed [22:0] msum;

  assign dsum         = {1'b0, d1} + {1'b0, d2};
  assign preset_duty  = dsum[16:1];
  assign msum         = {i1[31], i1[31:10]} + {i2[31], i2[31:10]};
  assign preset_integ = {msum[22:1], 10'd0};

  logic [15:0] last_duty [NUM_PHASES];
  logic [15:0] out_duty [NUM_PHASES];
  logic        commutating;

  assign commutating = (lane_role(ctrl.sector, PHASE_A) != ROLE_NONE);

  always_comb begin
    for (int i = 0; i < NUM_PHASES; i++) begin
      if (!commutating) begin
        out_duty[i] = last_duty[i];
      end else if (lane_role(ctrl.sector, i) == ROLE_IDLE) begin
        out_duty[i] = 16'd0;
      end else begin
        out_duty[i] = step_duty[i];
      end
    end
  end

  ssc_result_t result_next;

  always_comb begin
    if (ctrl.enable) begin
      result_next.duty_a   = out_duty[PHASE_A];
      result_next.duty_b   = out_duty[PHASE_B];
      result_next.duty_c   = out_duty[PHASE_C];
      result_next.gates_on = 1'b1;
    end else begin
      result_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      for (int i = 0; i < NUM_PHASES; i++) begin
        last_duty[i] <= '0;
      end
    end else if (ctrl.advance) begin
      result_valid <= ctrl.valid;
      if (ctrl.valid && ctrl.enable && commutating) begin
        for (int i = 0; i < NUM_PHASES; i++) begin
          last_duty[i] <= out_duty[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      result <= result_next;
    end
  end

endmodule

FILE: rtl/six_step_phase_current_control_unit.sv
// Six-step phase current controller. Each request carries an enable bit, the
// Hall sector, the signed current request and the three measured phase
// currents; each produces exactly one result with three PWM compare values and
// the gate enable. Three identical phase lanes run a PI step side by side, and
// a merging stage presets the idle phase in the two-phase sectors and forms the
// outputs. A request may be accepted on every clock cycle while the result
// side is not stalled: the lanes are split into a product stage and an update
// stage, and a result moves from the product-stage registers to the output
// register, taken when the result side is ready. The per-phase integrator and
// duty loop back inside the update stage, so back-to-back requests see each
// other's state with no gap. A stalled result is held in the output register
// while one more request can still enter the product stage. The configuration
// port is always ready; write registers only while no request is in flight.
module six_step_phase_current_control_unit
  import ssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  ssc_sample_t sample,
  output logic        result_valid,
  input  logic        result_ready,
  output ssc_result_t result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers. An index beyond the list is ignored.
  logic [15:0] max_duty;
  logic [15:0] prop_gain;
  logic [15:0] integral_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duty      <= MAX_DUTY_RESET;
      prop_gain     <= PROP_GAIN_RESET;
      integral_gain <= INTEGRAL_GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_DUTY:      max_duty      <= cfg_data;
        REG_PROP_GAIN:     prop_gain     <= cfg_data;
        REG_INTEGRAL_GAIN: integral_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control. The product stage moves on whenever the output register
  // is empty or being taken.
  logic       s1_valid;
  logic       s1_enable;
  logic [2:0] s1_sector;
  logic       advance;
  logic       load;

  assign advance      = !result_valid || result_ready;
  assign sample_ready = !s1_valid || advance;
  assign load         = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_enable <= sample.enable;
      s1_sector <= sample.sector;
    end
  end

  // Targets: half the request is a floor shift; minus half negates that.
  logic signed [16:0] full_req;
  logic signed [16:0] half_req;
  logic signed [16:0] neg_half_req;

  assign full_req     = {sample.current_request[15], sample.current_request};
  assign half_req     = {{2{sample.current_request[15]}}, sample.current_request[15:1]};
  assign neg_half_req = 17'sd0 - half_req;

  logic signed [15:0] meas [NUM_PHASES];

  assign meas[PHASE_A] = sample.current_a;
  assign meas[PHASE_B] = sample.current_b;
  assign meas[PHASE_C] = sample.current_c;

  logic signed [31:0] step_integ [NUM_PHASES];
  logic [15:0]        step_duty [NUM_PHASES];
  logic signed [31:0] preset_integ;
  logic [15:0]        preset_duty;
  logic               commit;

  // The update stage commits state only for enabled requests.
  assign commit = s1_valid && advance && s1_enable;

  for (genvar g = 0; g < NUM_PHASES; g++) begin : g_lane
    logic [2:0]         in_role;
    logic [2:0]         s1_role;
    logic signed [16:0] target;
    lane_ctrl_t         ctrl;

    assign in_role = lane_role(sample.sector, g);
    assign s1_role = lane_role(s1_sector, g);

    always_comb begin
      case (in_role)
        ROLE_HALF:     target = half_req;
        ROLE_FULL:     target = full_req;
        ROLE_NEG_HALF: target = neg_half_req;
        default:       target = 17'sd0;
      endcase
    end

    assign ctrl.load   = load;
    assign ctrl.step   = commit && (s1_role == ROLE_HALF || s1_role == ROLE_FULL ||
                                    s1_role == ROLE_NEG_HALF);
    assign ctrl.preset = commit && (s1_role == ROLE_IDLE);

    ssc_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .target        (target),
      .meas          (meas[g]),
      .max_duty      (max_duty),
      .prop_gain     (prop_gain),
      .integral_gain (integral_gain),
      .preset_integ  (preset_integ),
      .preset_duty   (preset_duty),
      .step_integ    (step_integ[g]),
      .step_duty     (step_duty[g])
    );
  end

  stage_ctrl_t merge_ctrl;

  assign merge_ctrl.advance = advance;
  assign merge_ctrl.valid   = s1_valid;
  assign merge_ctrl.enable  = s1_enable;
  assign merge_ctrl.sector  = s1_sector;

  ssc_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (merge_ctrl),
    .step_integ   (step_integ),
    .step_duty    (step_duty),
    .preset_integ (preset_integ),
    .preset_duty  (preset_duty),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

FILE: rtl/ssc_checker.sv
module ssc_checker
  import ssc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input ssc_result_t result,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // The input side only backs up when the output side is stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> result_valid && !result_ready)
    else $error("request refused without an output stall");

  // Gates off means every compare value is zero.
  a_shutdown_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.gates_on |->
      result.duty_a == 16'd0 && result.duty_b == 16'd0 && result.duty_c == 16'd0)
    else $error("nonzero duty with gates off");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind six_step_phase_current_control_unit ssc_checker u_ssc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

FILE: tb/sv/six_step_phase_current_control_unit_tb.sv
`timescale 1ns / 100ps

module six_step_phase_current_control_unit_tb;
  import ssc_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 6;
  // A request passes from the product-stage registers into the output register,
  // so waiting this long after the last result is plenty to be sure the block
  // has gone quiet.
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASE_COUNT     = 8;
  localparam int PHASE_REQUESTS  = 250;

  // Index 3 is not mapped to any register, so a write to it must be dropped.
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // Stall patterns of the result side.
  typedef enum int {
    RCV_ALWAYS,
    RCV_COIN,
    RCV_SPARSE,
    RCV_EVERY_THIRD
  } rcv_mode_e;

  // One line of the directed sequence: either a register write or a request.
  // A request may carry a result that is obvious by inspection; all others
  // are checked against the duty predictor below.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_val;
    ssc_sample_t smp;
    bit          has_lit;
    ssc_result_t lit;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  ssc_sample_t sample = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  ssc_result_t result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow of the controller: per-phase integrator, duty and the duties last
  // shown on the outputs, plus the three gain/limit registers.
  int integ_q  [NUM_PHASES] = '{default: 0};
  int duty_q   [NUM_PHASES] = '{default: 0};
  int shown_q  [NUM_PHASES] = '{default: 0};
  int cfg_max_duty  = int'(MAX_DUTY_RESET);
  int cfg_prop_gain = int'(PROP_GAIN_RESET);
  int cfg_int_gain  = int'(INTEGRAL_GAIN_RESET);

  // Duties still owed by the block, oldest first.
  ssc_result_t pending_q[$];

  // Literal result attached to the request currently offered, if any.
  bit          lit_pending = 1'b0;
  ssc_result_t lit_value = '0;

  bit hold_off_req = 1'b0;
  int hold_offs_done = 0;
  int error_count = 0;
  int requests_accepted = 0;
  int results_checked = 0;
  int stuck_cycles = 0;

  six_step_phase_current_control_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Duty predictor.
  // ---------------------------------------------------------------------------

  // The integrator is a signed 32-bit register that saturates instead of
  // wrapping.
  function automatic int clip32(longint x);
    if (x > longint'(32'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end
    if (x < longint'(32'sh8000_0000)) begin
      return 32'sh8000_0000;
    end
    return int'(x);
  endfunction

  function automatic logic signed [15:0] clip16(int x);
    if (x > 32767) begin
      return 16'sh7FFF;
    end
    if (x < -32768) begin
      return 16'sh8000;
    end
    return 16'(x);
  endfunction

  // One PI step on a phase. Anti-windup: the integrator does not move while
  // the duty sits at a rail and the error would push it further into it.
  function automatic void pi_update(int ph, longint target, longint meas);
    longint err;
    longint level;
    bit     hold;
    err  = target - meas;
    hold = (err > 0 && duty_q[ph] == cfg_max_duty) || (err < 0 && duty_q[ph] == 0);
    if (!hold) begin
      integ_q[ph] = clip32(longint'(integ_q[ph]) + err * longint'(cfg_int_gain));
    end
    level = (err * longint'(cfg_prop_gain) + (longint'(integ_q[ph]) >>> 10) - meas) >>> 7;
    if (level < 0) begin
      level = 0;
    end
    if (level > longint'(cfg_max_duty)) begin
      level = longint'(cfg_max_duty);
    end
    duty_q[ph] = int'(level);
  endfunction

  // The undriven phase of a two-phase sector is primed with the mean duty and
  // the mean integrator (whole units of 2^10) of the two driven phases, so it
  // takes over smoothly at the next commutation.
  function automatic void preset_idle_phase(int idle, int p1, int p2);
    longint mean_i;
    mean_i = ((longint'(integ_q[p1]) >>> 10) + (longint'(integ_q[p2]) >>> 10)) >>> 1;
    duty_q[idle]  = (duty_q[p1] + duty_q[p2]) >> 1;
    integ_q[idle] = clip32(mean_i * 1024);
  endfunction

  function automatic ssc_result_t predict_duties(ssc_sample_t s);
    ssc_result_t r;
    longint      req;
    longint      half;
    longint      ma;
    longint      mb;
    longint      mc;
    r    = '0;
    req  = longint'(s.current_request);
    half = req >>> 1;
    ma   = longint'(s.current_a);
    mb   = longint'(s.current_b);
    mc   = longint'(s.current_c);
    if (s.enable) begin
      case (s.sector)
        3'd0: begin
          pi_update(PHASE_A, half, ma);
          pi_update(PHASE_B, half, mb);
          preset_idle_phase(PHASE_C, PHASE_A, PHASE_B);
          shown_q = '{duty_q[PHASE_A], duty_q[PHASE_B], 0};
        end
        3'd1: begin
          pi_update(PHASE_B, req, mb);
          pi_update(PHASE_A, -half, ma);
          pi_update(PHASE_C, -half, mc);
          shown_q = duty_q;
        end
        3'd2: begin
          pi_update(PHASE_B, half, mb);
          pi_update(PHASE_C, half, mc);
          preset_idle_phase(PHASE_A, PHASE_B, PHASE_C);
          shown_q = '{0, duty_q[PHASE_B], duty_q[PHASE_C]};
        end
        3'd3: begin
          pi_update(PHASE_C, req, mc);
          pi_update(PHASE_A, -half, ma);
          pi_update(PHASE_B, -half, mb);
          shown_q = duty_q;
        end
        3'd4: begin
          pi_update(PHASE_A, half, ma);
          pi_update(PHASE_C, half, mc);
          preset_idle_phase(PHASE_B, PHASE_A, PHASE_C);
          shown_q = '{duty_q[PHASE_A], 0, duty_q[PHASE_C]};
        end
        3'd5: begin
          pi_update(PHASE_A, req, ma);
          pi_update(PHASE_B, -half, mb);
          pi_update(PHASE_C, -half, mc);
          shown_q = duty_q;
        end
        default: begin
          // Invalid Hall code: nothing is updated, the last duties repeat.
        end
      endcase
      r.duty_a   = 16'(shown_q[PHASE_A]);
      r.duty_b   = 16'(shown_q[PHASE_B]);
      r.duty_c   = 16'(shown_q[PHASE_C]);
      r.gates_on = 1'b1;
    end
    // When disabled the outputs are all zero and no state moves.
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: checks results, tracks register writes, predicts every accepted
  // request and runs the watchdog. Everything is sampled at the rising edge,
  // while the stimulus only moves at the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ssc_result_t want;
    ssc_result_t got;
    ssc_result_t predicted;
    bit          moved;
    if (!rst) begin
      moved = 1'b0;

      if (result_valid && result_ready) begin
        moved = 1'b1;
        got   = result;
        if (pending_q.size() == 0) begin
          $error("result with no request outstanding: duty_a %0d duty_b %0d duty_c %0d gates %0d",
                 got.duty_a, got.duty_b, got.duty_c, got.gates_on);
          error_count++;
        end else begin
          want = pending_q.pop_front();
          results_checked++;
          if (got.duty_a !== want.duty_a) begin
            $error("duty_a expected %0d got %0d", want.duty_a, got.duty_a);
            error_count++;
          end
          if (got.duty_b !== want.duty_b) begin
            $error("duty_b expected %0d got %0d", want.duty_b, got.duty_b);
            error_count++;
          end
          if (got.duty_c !== want.duty_c) begin
            $error("duty_c expected %0d got %0d", want.duty_c, got.duty_c);
            error_count++;
          end
          if (got.gates_on !== want.gates_on) begin
            $error("gates_on expected %0d got %0d", want.gates_on, got.gates_on);
            error_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_MAX_DUTY:      cfg_max_duty  = int'(cfg_data);
          REG_PROP_GAIN:     cfg_prop_gain = int'(cfg_data);
          REG_INTEGRAL_GAIN: cfg_int_gain  = int'(cfg_data);
          default: begin
            // Unmapped index: the block must ignore the write.
          end
        endcase
      end

      if (sample_valid && sample_ready) begin
        moved     = 1'b1;
        predicted = predict_duties(sample);
        pending_q.push_back(lit_pending ? lit_value : predicted);
        requests_accepted++;
      end

      // The watchdog only trips when no channel has moved for a long time,
      // which no legal stall pattern here comes close to.
      if (moved) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                   WATCHDOG_LIMIT, pending_q.size());
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: switches between stall patterns at random intervals. When
  // asked, it refuses results for a long stretch so that the pipeline backs up
  // and the request side sees ready drop.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    rcv_mode_e mode;
    int        mode_left;
    mode      = RCV_ALWAYS;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_offs_done++;
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = rcv_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RCV_ALWAYS: result_ready <= 1'b1;
          RCV_COIN:   result_ready <= 1'($urandom_range(0, 1));
          RCV_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
          default:    result_ready <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side helpers.
  // ---------------------------------------------------------------------------

  // Offers one request and holds it until the block takes it. Valid stays up
  // on return so that a following request goes out back to back.
  task automatic send_request(ssc_sample_t s, bit use_literal, ssc_result_t literal);
    @(negedge clk);
    sample_valid <= 1'b1;
    sample       <= s;
    lit_pending  = use_literal;
    lit_value    = literal;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic sender_pause(int cycles);
    @(negedge clk);
    sample_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Registers may only change with nothing in flight.
  task automatic wait_drained();
    sender_pause(1);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic dir_row_t row_req(bit en, int sec, int req, int ca, int cb, int cc);
    dir_row_t r;
    r.is_cfg                = 1'b0;
    r.cfg_idx               = '0;
    r.cfg_val               = '0;
    r.smp.enable            = en;
    r.smp.sector            = 3'(sec);
    r.smp.current_request   = 16'(req);
    r.smp.current_a         = 16'(ca);
    r.smp.current_b         = 16'(cb);
    r.smp.current_c         = 16'(cc);
    r.has_lit               = 1'b0;
    r.lit                   = '0;
    return r;
  endfunction

  // Rows whose answer is plain: all duties zero, gates following enable.
  function automatic dir_row_t row_fixed(bit en, int sec, int req, int ca, int cb, int cc);
    dir_row_t r;
    r             = row_req(en, sec, req, ca, cb, cc);
    r.has_lit     = 1'b1;
    r.lit.gates_on = en;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(logic [1:0] idx, logic [15:0] val);
    dir_row_t r;
    r         = row_req(1'b0, 0, 0, 0, 0, 0);
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    plan[$];
    ssc_sample_t s;
    int          tgt [NUM_PHASES];
    int          run_left;
    int          seq_sector;
    int          req_amp;
    int          noise_amp;
    int          req;
    int          half;
    int          mx;
    int          pg;
    int          ig;
    int          directed_count;
    int          settings_count;

    // With the reset limit of zero every duty clamps to zero, so the first
    // requests can be answered by inspection: disabled, the rails of every
    // field, and an invalid Hall code.
    plan.push_back(row_fixed(1'b0, 0, 0, 0, 0, 0));
    plan.push_back(row_fixed(1'b1, 0, 32767, -32768, -32768, -32768));
    plan.push_back(row_fixed(1'b1, 7, -32768, 32767, 32767, 32767));
    plan.push_back(row_fixed(1'b0, 5, -1, -1, -1, -1));
    // Every register at its top value, plus a write to the unmapped index.
    plan.push_back(row_cfg(REG_MAX_DUTY, 16'hFFFF));
    plan.push_back(row_cfg(REG_PROP_GAIN, 16'hFFFF));
    plan.push_back(row_cfg(REG_INTEGRAL_GAIN, 16'hFFFF));
    plan.push_back(row_cfg(REG_UNMAPPED, 16'h1234));
    // Full-scale errors drive the integrators into saturation in one step;
    // repeating the same request then holds them against the rails.
    plan.push_back(row_req(1'b1, 0, 32767, -32768, -32768, 0));
    plan.push_back(row_req(1'b1, 0, 32767, -32768, -32768, 0));
    plan.push_back(row_req(1'b1, 1, -32768, 32767, 32767, 32767));
    plan.push_back(row_req(1'b1, 1, -32768, 32767, 32767, 32767));
    plan.push_back(row_req(1'b1, 2, 12345, 0, 100, -100));
    plan.push_back(row_req(1'b1, 3, 32767, 32767, 32767, 32767));
    plan.push_back(row_req(1'b1, 4, -20000, 5, -5, 7));
    plan.push_back(row_req(1'b1, 5, -32768, -32768, -32768, -32768));
    plan.push_back(row_req(1'b1, 6, 1, 2, 3, 4));
    plan.push_back(row_fixed(1'b0, 3, 777, -777, 777, -777));
    // Back from shutdown on an invalid code: the duties before shutdown return.
    plan.push_back(row_req(1'b1, 7, 0, 0, 0, 0));
    // Reset gains with a moderate limit, currents close to their targets.
    plan.push_back(row_cfg(REG_MAX_DUTY, 16'd1000));
    plan.push_back(row_cfg(REG_PROP_GAIN, PROP_GAIN_RESET));
    plan.push_back(row_cfg(REG_INTEGRAL_GAIN, INTEGRAL_GAIN_RESET));
    plan.push_back(row_req(1'b1, 1, 2000, -1000, 2000, -1000));
    plan.push_back(row_req(1'b1, 1, 2000, -900, 1800, -1100));
    plan.push_back(row_req(1'b1, 2, 2000, 0, 900, 1100));
    plan.push_back(row_req(1'b1, 3, -3000, 1500, 1400, -2900));
    plan.push_back(row_req(1'b1, 4, 500, 250, 0, 260));
    plan.push_back(row_req(1'b1, 5, 0, 10, -10, 0));
    plan.push_back(row_req(1'b1, 0, 1000, 500, 500, 0));

    directed_count = 0;
    settings_count = 3;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        cfg_write(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_request(plan[i].smp, plan[i].has_lit, plan[i].lit);
        directed_count++;
      end
    end

    // Random part: several register settings, each followed by a run of
    // requests. Most requests follow the normal commutation order with phase
    // currents near their targets, so the PI loops wander through the whole
    // duty range; the rest is unconstrained noise on every field.
    run_left   = 0;
    seq_sector = 0;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin mx = 2000;  pg = 15;    ig = 7000;  end
        1: begin mx = 65535; pg = 0;     ig = 0;     end
        2: begin mx = 0;     pg = 65535; ig = 65535; end
        4: begin mx = 4095;  pg = 40;    ig = 2000;  end
        6: begin mx = 65535; pg = 65535; ig = 65535; end
        default: begin
          mx = $urandom_range(0, 65535);
          pg = $urandom_range(0, 300);
          ig = $urandom_range(0, 65535);
        end
      endcase
      wait_drained();
      cfg_write(REG_MAX_DUTY, 16'(mx));
      cfg_write(REG_PROP_GAIN, 16'(pg));
      cfg_write(REG_INTEGRAL_GAIN, 16'(ig));
      cfg_write(REG_UNMAPPED, 16'($urandom));
      settings_count++;

      req_amp   = (ph % 2 == 1) ? 32767 : 4000;
      noise_amp = $urandom_range(0, 400);

      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        // In two of the runs the result side stops for a long while; keep the
        // request side busy meanwhile so the pipeline fills and pushes back.
        if ((ph == 2 || ph == 5) && k == 100) begin
          hold_off_req = 1'b1;
          run_left     = 60;
        end
        if (run_left == 0) begin
          if ($urandom_range(0, 3) != 0) begin
            sender_pause($urandom_range(1, 12));
          end
          run_left = $urandom_range(1, 40);
        end
        run_left--;

        if ($urandom_range(0, 4) == 0) begin
          s.enable          = 1'($urandom);
          s.sector          = 3'($urandom);
          s.current_request = 16'($urandom);
          s.current_a       = 16'($urandom);
          s.current_b       = 16'($urandom);
          s.current_c       = 16'($urandom);
        end else begin
          if ($urandom_range(0, 15) == 0) begin
            seq_sector = $urandom_range(0, 7);
          end else begin
            seq_sector = (seq_sector >= 5) ? 0 : seq_sector + 1;
          end
          req  = int'($urandom_range(0, 2 * req_amp)) - req_amp;
          half = req >>> 1;
          case (seq_sector)
            0:       tgt = '{half, half, 0};
            1:       tgt = '{-half, req, -half};
            2:       tgt = '{0, half, half};
            3:       tgt = '{-half, -half, req};
            4:       tgt = '{half, 0, half};
            5:       tgt = '{req, -half, -half};
            default: tgt = '{0, 0, 0};
          endcase
          s.enable          = ($urandom_range(0, 19) != 0);
          s.sector          = 3'(seq_sector);
          s.current_request = 16'(req);
          s.current_a = clip16(tgt[PHASE_A] + int'($urandom_range(0, 2 * noise_amp)) - noise_amp);
          s.current_b = clip16(tgt[PHASE_B] + int'($urandom_range(0, 2 * noise_amp)) - noise_amp);
          s.current_c = clip16(tgt[PHASE_C] + int'($urandom_range(0, 2 * noise_amp)) - noise_amp);
        end
        send_request(s, 1'b0, '0);
      end
    end

    wait_drained();

    $display("Covered %0d requests (%0d directed) over %0d register settings, all Hall codes,",
             requests_accepted, directed_count, settings_count);
    $display("enable on and off; %0d results checked, %0d long result-side hold-offs.",
             results_checked, hold_offs_done);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
